@@ src/rfe_pkg.sv @@
// ----------------------------------------------------------------------------
// rfe_pkg
// shared types, ascii constants and crc8 helpers for the request frame encoder
// ----------------------------------------------------------------------------
package rfe_pkg;

   localparam logic [7:0] CRC_POLY       = 8'h07;
   localparam logic [7:0] WRITE_CODE_RST = 8'd87;   // 'W'

   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_A_LOWER = 8'h61;
   localparam logic [7:0] ASCII_SPACE   = 8'h20;
   localparam logic [7:0] ASCII_STAR    = 8'h2a;
   localparam logic [7:0] ASCII_NL      = 8'h0a;

   // one classified frame waiting to be serialized
   typedef struct packed {
      logic        is_write;
      logic [7:0]  code;
      logic [7:0]  param;
      logic [15:0] value;
      logic [7:0]  crc;
      logic        param_top;   // index of the leading param digit
      logic [1:0]  value_top;   // index of the leading value digit
      logic        crc_top;     // index of the leading crc digit
   } rfe_entry_type;

   typedef logic [7:0] crc_table_type [256];

   // one crc8 byte step, msb first, no reflection
   function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] d;
      d = acc ^ b;
      for (int k = 0; k < 8; k++) begin
         d = d[7] ? ((d << 1) ^ CRC_POLY) : (d << 1);
      end
      return d;
   endfunction

   // contribution of a byte followed by (depth - 1) more bytes; crc8 with zero
   // init is linear, so the frame crc is the xor of one entry per byte
   function automatic crc_table_type crc_table(input int unsigned depth);
      crc_table_type t;
      logic [7:0]    v;
      for (int i = 0; i < 256; i++) begin
         v = 8'(i);
         for (int unsigned k = 0; k < depth; k++) begin
            v = crc_byte(v, 8'h00);
         end
         t[i] = v;
      end
      return t;
   endfunction

   function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = ASCII_ZERO + {4'h0, nib};
      end else begin
         r = ASCII_A_LOWER - 8'd10 + {4'h0, nib};
      end
      return r;
   endfunction

endpackage

@@ src/request_frame_encoder_core.sv @@
// ----------------------------------------------------------------------------
// request_frame_encoder_core
// turns requests into newline-terminated ascii frames with a crc8 trailer
// ----------------------------------------------------------------------------
// usage
//   req_* is the request channel (valid/ready); one beat is one request, either a
//   plain command (code, hex parameter) or a register write (write code, hex
//   address, space, hex value). rsp_* carries the frame one ascii byte per beat,
//   rsp_last_byte marks the closing newline. csr_write_enable / csr_write_data
//   load the register-write code letter (reset value 'W'); write it only idle.
// datapath and throughput
//   the front classifies and computes the crc in the accept cycle and pushes
//   into a two-entry queue; a frame then passes the queue slot, the serializer's
//   current-frame register and the output register before it shows on rsp.
//   the serializer emits one byte per cycle while the receiver is ready, with
//   frames back to back and no gap; a frame is 5 to 7 bytes for plain
//   commands, 7 to 12 bytes for register writes.
// reset and stalls
//   synchronous reset empties the queue and the output register and restores
//   the write code. a stalled receiver holds the current byte in the output
//   register; the queue keeps taking requests until both entries are full.
// ----------------------------------------------------------------------------
module request_frame_encoder_core
   import rfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_cmd_code,
   input  logic [7:0]  req_param_byte,
   input  logic [15:0] req_write_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte
);

   rfe_entry_type front_entry;
   rfe_entry_type queue_entry;
   logic          queue_valid;
   logic          queue_pop;

   // front: write code register, crc and digit-count classification
   rfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_type         (req_type),
      .req_cmd_code     (req_cmd_code),
      .req_param_byte   (req_param_byte),
      .req_write_value  (req_write_value),
      .entry            (front_entry)
   );

   // decoupling queue; its free space is the request-side ready
   rfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_entry (front_entry),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_entry  (queue_entry)
   );

   // back: byte sequencer with registered output beat
   rfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .entry_valid   (queue_valid),
      .entry         (queue_entry),
      .entry_pop     (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

@@ src/rfe_front.sv @@
// ----------------------------------------------------------------------------
// rfe_front
// holds the write code register, classifies a request and computes its crc
// ----------------------------------------------------------------------------
module rfe_front
   import rfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [7:0]    csr_write_data,
   input  logic          req_type,
   input  logic [7:0]    req_cmd_code,
   input  logic [7:0]    req_param_byte,
   input  logic [15:0]   req_write_value,
   output rfe_entry_type entry
);

   localparam crc_table_type CRC_T1 = crc_table(1);
   localparam crc_table_type CRC_T2 = crc_table(2);
   localparam crc_table_type CRC_T3 = crc_table(3);
   localparam crc_table_type CRC_T4 = crc_table(4);

   logic [7:0]  write_code_ff;
   logic [7:0]  write_code_in;
   logic [7:0]  code;
   logic [15:0] value;

   assign write_code_in = csr_write_enable ? csr_write_data : write_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_code_ff <= WRITE_CODE_RST;
      end else begin
         write_code_ff <= write_code_in;
      end
   end

   assign code  = req_type ? write_code_ff : req_cmd_code;
   assign value = req_type ? req_write_value : 16'h0000;

   always_comb begin
      entry.is_write  = req_type;
      entry.code      = code;
      entry.param     = req_param_byte;
      entry.value     = value;
      entry.crc       = CRC_T4[code] ^ CRC_T3[req_param_byte] ^
                        CRC_T2[value[7:0]] ^ CRC_T1[value[15:8]];
      entry.param_top = (req_param_byte[7:4] != 4'h0);
      if (value[15:12] != 4'h0) begin
         entry.value_top = 2'd3;
      end else if (value[11:8] != 4'h0) begin
         entry.value_top = 2'd2;
      end else if (value[7:4] != 4'h0) begin
         entry.value_top = 2'd1;
      end else begin
         entry.value_top = 2'd0;
      end
      entry.crc_top   = (entry.crc[7:4] != 4'h0);
   end

endmodule

@@ src/rfe_queue.sv @@
// ----------------------------------------------------------------------------
// rfe_queue
// two-entry queue of classified frames between front and back
// ----------------------------------------------------------------------------
module rfe_queue
   import rfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  rfe_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop,
   output rfe_entry_type pop_entry
);

   rfe_entry_type slot_ff [2];
   logic          wr_ptr_ff;
   logic          wr_ptr_in;
   logic          rd_ptr_ff;
   logic          rd_ptr_in;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;
   logic          push;
   logic          take;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign take       = pop && pop_valid;

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, take};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/rfe_back.sv @@
// ----------------------------------------------------------------------------
// rfe_back
// serializes one classified frame into ascii beats through an output register
// ----------------------------------------------------------------------------
module rfe_back
   import rfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          entry_valid,
   input  rfe_entry_type entry,
   output logic          entry_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_tx_byte,
   output logic          rsp_last_byte
);

   localparam logic [2:0] S_CODE  = 3'd0;
   localparam logic [2:0] S_PARAM = 3'd1;
   localparam logic [2:0] S_SPACE = 3'd2;
   localparam logic [2:0] S_VALUE = 3'd3;
   localparam logic [2:0] S_STAR  = 3'd4;
   localparam logic [2:0] S_CRC   = 3'd5;
   localparam logic [2:0] S_NL    = 3'd6;

   rfe_entry_type cur_ff;
   rfe_entry_type cur_in;
   logic [2:0]    seq_ff;
   logic [2:0]    seq_in;
   logic [1:0]    dig_ff;
   logic [1:0]    dig_in;
   logic          busy_ff;
   logic          busy_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    rsp_tx_byte_ff;
   logic [7:0]    rsp_tx_byte_in;
   logic          rsp_last_byte_ff;
   logic          rsp_last_byte_in;

   logic          can_load;
   logic          emit;
   logic          finish;
   logic [15:0]   field;
   logic [3:0]    nib;
   logic [7:0]    beat_byte;
   logic [2:0]    seq_adv;
   logic [1:0]    dig_adv;

   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign emit      = busy_ff && can_load;
   assign finish    = emit && (seq_ff == S_NL);
   assign entry_pop = entry_valid && (!busy_ff || finish);

   // digit source for the hex fields
   always_comb begin
      case (seq_ff)
         S_PARAM: field = {8'h00, cur_ff.param};
         S_VALUE: field = cur_ff.value;
         default: field = {8'h00, cur_ff.crc};
      endcase
      nib = 4'(field >> {dig_ff, 2'b00});
   end

   always_comb begin
      beat_byte = ASCII_NL;
      seq_adv   = seq_ff;
      dig_adv   = dig_ff;
      case (seq_ff)
         S_CODE: begin
            beat_byte = cur_ff.code;
            seq_adv   = S_PARAM;
            dig_adv   = {1'b0, cur_ff.param_top};
         end
         S_PARAM: begin
            beat_byte = hex_ascii(nib);
            if (dig_ff == 2'd0) begin
               seq_adv = cur_ff.is_write ? S_SPACE : S_STAR;
            end else begin
               dig_adv = dig_ff - 2'd1;
            end
         end
         S_SPACE: begin
            beat_byte = ASCII_SPACE;
            seq_adv   = S_VALUE;
            dig_adv   = cur_ff.value_top;
         end
         S_VALUE: begin
            beat_byte = hex_ascii(nib);
            if (dig_ff == 2'd0) begin
               seq_adv = S_STAR;
            end else begin
               dig_adv = dig_ff - 2'd1;
            end
         end
         S_STAR: begin
            beat_byte = ASCII_STAR;
            seq_adv   = S_CRC;
            dig_adv   = {1'b0, cur_ff.crc_top};
         end
         S_CRC: begin
            beat_byte = hex_ascii(nib);
            if (dig_ff == 2'd0) begin
               seq_adv = S_NL;
            end else begin
               dig_adv = dig_ff - 2'd1;
            end
         end
         S_NL: begin
            beat_byte = ASCII_NL;
            seq_adv   = S_CODE;
            dig_adv   = 2'd0;
         end
         default: begin
            beat_byte = ASCII_NL;
            seq_adv   = S_CODE;
            dig_adv   = 2'd0;
         end
      endcase
   end

   always_comb begin
      cur_in  = cur_ff;
      seq_in  = seq_ff;
      dig_in  = dig_ff;
      busy_in = busy_ff;
      if (entry_pop) begin
         cur_in  = entry;
         seq_in  = S_CODE;
         dig_in  = 2'd0;
         busy_in = 1'b1;
      end else if (finish) begin
         seq_in  = S_CODE;
         dig_in  = 2'd0;
         busy_in = 1'b0;
      end else if (emit) begin
         seq_in  = seq_adv;
         dig_in  = dig_adv;
      end
   end

   assign rsp_valid_in     = can_load ? emit : rsp_valid_ff;
   assign rsp_tx_byte_in   = can_load ? beat_byte : rsp_tx_byte_ff;
   assign rsp_last_byte_in = can_load ? (seq_ff == S_NL) : rsp_last_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_CODE;
         dig_ff       <= 2'd0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         dig_ff       <= dig_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff           <= cur_in;
      rsp_tx_byte_ff   <= rsp_tx_byte_in;
      rsp_last_byte_ff <= rsp_last_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = rsp_tx_byte_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

   // the frame flag only ever rides on the closing newline
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_byte_ff |-> rsp_tx_byte_ff == ASCII_NL)
      else $error("last beat is not a newline");

   // an idle serializer sits at the frame start
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> seq_ff == S_CODE && dig_ff == 2'd0)
      else $error("idle serializer not at frame start");

   // the space and value digits belong to register writes only
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && (seq_ff == S_SPACE || seq_ff == S_VALUE) |-> cur_ff.is_write)
      else $error("write fields in a plain command frame");

   // a new frame is never taken while the current one still has beats left
   assert property (@(posedge clock) disable iff (reset)
      entry_pop && busy_ff |-> emit && seq_ff == S_NL)
      else $error("frame popped mid-serialization");

endmodule

@@ tb/request_frame_encoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// request_frame_encoder_core_tb
// self-checking bench: every accepted request is encoded into its expected
// ascii frame (code, hex fields, crc8 trailer, newline) and each response
// beat is compared in order against that frame, under random idling on both
// channels and several write-code settings
// ----------------------------------------------------------------------------
module request_frame_encoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rfe_pkg::*;

   // request kinds on req_type
   localparam logic REQ_PLAIN = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam int MAX_REPORTS  = 10;
   localparam int TAIL_CYCLES  = 16;     // beyond the deepest frame latency
   localparam int TIMEOUT_NS   = 4_000_000;

   // one byte of an expected frame
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   // dut ports; the inputs are known from time zero
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data   = 8'h00;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_type         = REQ_PLAIN;
   logic [7:0]  req_cmd_code     = 8'h00;
   logic [7:0]  req_param_byte   = 8'h00;
   logic [15:0] req_write_value  = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_byte;

   // bench state
   frame_byte_type frame_bytes_due[$];   // bytes still owed by the dut, oldest first
   logic [7:0]  write_code_shadow = WRITE_CODE_RST;
   bit          idling_on         = 1'b1;
   int          mismatch_count    = 0;
   int          bytes_checked     = 0;
   int          frames_seen       = 0;
   int          plain_requests    = 0;
   int          write_requests    = 0;
   int          code_loads        = 0;
   int          rsp_stall_left    = 0;

   request_frame_encoder_core uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_cmd_code     (req_cmd_code),
      .req_param_byte   (req_param_byte),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_last_byte    (rsp_last_byte)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // frame prediction
   // ---------------------------------------------------------------------

   // crc8, poly 0x07, msb first, one input bit at a time
   function automatic logic [7:0] crc8_feed(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      logic       fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ b[i];
         r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   function automatic logic [7:0] nibble_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = ASCII_ZERO + 8'(nib);
      end else begin
         c = ASCII_A_LOWER + 8'(nib) - 8'd10;
      end
      return c;
   endfunction

   // minimal lower-case hex, zero gives a single '0'
   function automatic void owe_hex(input logic [15:0] v);
      int ndig;
      ndig = 1;
      while (ndig < 4 && (v >> (4 * ndig)) != 16'h0) ndig++;
      for (int i = ndig - 1; i >= 0; i--) begin
         frame_bytes_due.push_back(frame_byte_type'{nibble_char(v[4*i +: 4]), 1'b0});
      end
   endfunction

   // append the whole frame one request should produce
   function automatic void encode_frame(input logic        is_write,
                                        input logic [7:0]  cmd,
                                        input logic [7:0]  param,
                                        input logic [15:0] value);
      logic [7:0]  code;
      logic [15:0] second;
      logic [7:0]  crc;
      code   = is_write ? write_code_shadow : cmd;
      second = is_write ? value : 16'h0000;
      crc    = crc8_feed(8'h00, code);
      crc    = crc8_feed(crc, param);
      crc    = crc8_feed(crc, second[7:0]);
      crc    = crc8_feed(crc, second[15:8]);
      frame_bytes_due.push_back(frame_byte_type'{code, 1'b0});
      owe_hex({8'h00, param});
      if (is_write) begin
         frame_bytes_due.push_back(frame_byte_type'{ASCII_SPACE, 1'b0});
         owe_hex(second);
      end
      frame_bytes_due.push_back(frame_byte_type'{ASCII_STAR, 1'b0});
      owe_hex({8'h00, crc});
      frame_bytes_due.push_back(frame_byte_type'{ASCII_NL, 1'b1});
   endfunction

   function automatic void report_mismatch(input string what, input int exp_v, input int got_v);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t ns: mismatch on %s, expected 0x%02h, got 0x%02h",
                  $time, what, exp_v, got_v);
      end
   endfunction

   // ---------------------------------------------------------------------
   // monitor: checks response beats, then books new requests, all at the
   // rising edge so ordering within the step never matters
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      frame_byte_type due;
      if (reset) begin
         write_code_shadow = WRITE_CODE_RST;
      end else begin
         // response beat first: it can only belong to an older request
         if (rsp_valid && rsp_ready) begin
            bytes_checked++;
            if (rsp_last_byte === 1'b1) frames_seen++;
            if (frame_bytes_due.size() == 0) begin
               report_mismatch("unexpected beat tx_byte", 0, rsp_tx_byte);
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_tx_byte !== due.data) begin
                  report_mismatch("tx_byte", due.data, rsp_tx_byte);
               end
               if (rsp_last_byte !== due.last) begin
                  report_mismatch("last_byte", due.last, rsp_last_byte);
               end
            end
         end
         // accepted request: predict its frame with the current write code
         if (req_valid && req_ready) begin
            encode_frame(req_type, req_cmd_code, req_param_byte, req_write_value);
            if (req_type == REQ_WRITE) write_requests++;
            else plain_requests++;
         end
         if (csr_write_enable) begin
            write_code_shadow = csr_write_data;
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall bursts while idling is on
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_stall_left = $urandom_range(1, 12) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // sender side; every task is entered and left at a falling edge
   // ---------------------------------------------------------------------

   // one request beat, with an optional idle burst ahead of it
   task automatic send_request(input logic        kind,
                               input logic [7:0]  cmd,
                               input logic [7:0]  param,
                               input logic [15:0] value);
      int gap;
      gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      // valid stays high across back-to-back beats, payload just moves on
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_cmd_code    <= cmd;
      req_param_byte  <= param;
      req_write_value <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // random request; field sizes spread over every hex digit count
   task automatic send_random_request();
      logic        kind;
      logic [7:0]  cmd;
      logic [7:0]  param;
      logic [15:0] value;
      kind  = $urandom_range(0, 1) ? REQ_WRITE : REQ_PLAIN;
      cmd   = 8'($urandom);
      param = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      case ($urandom_range(0, 4))
         0: begin
            value = 16'($urandom_range(0, 15));
         end
         1: begin
            value = 16'($urandom_range(16, 255));
         end
         2: begin
            value = 16'($urandom_range(256, 4095));
         end
         default: begin
            value = 16'($urandom);
         end
      endcase
      send_request(kind, cmd, param, value);
   endtask

   task automatic wait_for_frames();
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(negedge clock);
   endtask

   // the write code only changes with nothing in flight
   task automatic load_write_code(input logic [7:0] code);
      wait_for_frames();
      csr_write_enable <= 1'b1;
      csr_write_data   <= code;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      code_loads++;
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // register writes with the reset write code
   task automatic test_default_write_code();
      send_request(REQ_WRITE, 8'h00, 8'h00, 16'h0000);
      send_request(REQ_WRITE, 8'hff, 8'hff, 16'hffff);
      send_request(REQ_WRITE, 8'h41, 8'h10, 16'h1000);
   endtask

   // plain commands at the field extremes, odd command bytes included
   task automatic test_plain_extremes();
      send_request(REQ_PLAIN, 8'h00, 8'h00, 16'hffff);   // value ignored
      send_request(REQ_PLAIN, 8'hff, 8'hff, 16'h0000);
      send_request(REQ_PLAIN, ASCII_NL, 8'h0f, 16'h1234);
      send_request(REQ_PLAIN, 8'h41, 8'h10, 16'h0000);
      send_request(REQ_PLAIN, ASCII_STAR, 8'h09, 16'h0000);
   endtask

   // write values of one, two and three hex digits
   task automatic test_value_widths();
      send_request(REQ_WRITE, 8'h00, 8'h01, 16'h000f);
      send_request(REQ_WRITE, 8'h00, 8'h0a, 16'h0010);
      send_request(REQ_WRITE, 8'h00, 8'h80, 16'h00ff);
      send_request(REQ_WRITE, 8'h00, 8'h7f, 16'h0100);
      send_request(REQ_WRITE, 8'h00, 8'hf0, 16'h0fff);
   endtask

   // write code at its extremes and as a newline byte
   task automatic test_write_code_extremes();
      load_write_code(8'h00);
      send_request(REQ_WRITE, 8'h57, 8'h00, 16'h0000);
      send_request(REQ_PLAIN, 8'h00, 8'h00, 16'h0000);
      load_write_code(8'hff);
      send_request(REQ_WRITE, 8'h00, 8'hff, 16'hffff);
      send_request(REQ_WRITE, 8'h00, 8'h5a, 16'ha5a5);
      load_write_code(ASCII_NL);
      send_request(REQ_WRITE, 8'h00, 8'h33, 16'h0c0c);
   endtask

   // random traffic in phases, new write code each phase, one phase quiet
   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) load_write_code(WRITE_CODE_RST);
         else load_write_code(8'($urandom));
         idling_on = (phase != 2);
         for (int n = 0; n < 60; n++) send_random_request();
      end
      idling_on = 1'b1;
   endtask

   // sender holds off mid-stream until the encoder has drained
   task automatic test_drain_pause();
      for (int n = 0; n < 20; n++) send_random_request();
      wait_for_frames();
      for (int n = 0; n < 20; n++) send_random_request();
   endtask

   // closing stretch at full rate on both sides
   task automatic test_back_to_back();
      idling_on = 1'b0;
      load_write_code(8'($urandom));
      for (int n = 0; n < 40; n++) send_random_request();
   endtask

   // ---------------------------------------------------------------------
   // run
   // ---------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_write_code();
      test_plain_extremes();
      test_value_widths();
      test_write_code_extremes();
      test_random_traffic();
      test_drain_pause();
      test_back_to_back();

      // let everything drain, then watch for stray beats
      wait_for_frames();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d plain commands and %0d register writes: %0d frames, %0d bytes",
               plain_requests, write_requests, frames_seen, bytes_checked);
      $display("write code reloaded %0d times, %0d mismatches", code_loads, mismatch_count);
      if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
         $display("request_frame_encoder_core_tb: PASS");
      end else begin
         $display("request_frame_encoder_core_tb: FAIL");
      end
      $finish;
   end

   // hard stop in case the handshake hangs
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d bytes still owed", frame_bytes_due.size());
      $display("request_frame_encoder_core_tb: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
src/rfe_pkg.sv
src/rfe_front.sv
src/rfe_queue.sv
src/rfe_back.sv
src/request_frame_encoder_core.sv
tb/request_frame_encoder_core_tb.sv
